FILE: rtl/pubs_pkg.sv
package pubs_pkg;

    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 512;
    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int HALF_COL_W = COL_W - 1;
    localparam int HALF_ROW_W = ROW_W - 1;

    // register indexes
    localparam logic [2:0] REG_CENTER_COL   = 3'd0;
    localparam logic [2:0] REG_CENTER_ROW   = 3'd1;
    localparam logic [2:0] REG_FRAME_WIDTH  = 3'd2;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd3;
    localparam logic [2:0] REG_ANGLE_STEP   = 3'd4;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    // quarter-wave sine, Q1.15 magnitude, 0..90 degrees
    function automatic logic [16:0] quarter_sine(input logic [6:0] d);
        logic [16:0] s;
        unique case (d)
            7'd0: s = 17'd0;      7'd1: s = 17'd572;    7'd2: s = 17'd1144;
            7'd3: s = 17'd1715;   7'd4: s = 17'd2286;   7'd5: s = 17'd2856;
            7'd6: s = 17'd3425;   7'd7: s = 17'd3993;   7'd8: s = 17'd4560;
            7'd9: s = 17'd5126;   7'd10: s = 17'd5690;  7'd11: s = 17'd6252;
            7'd12: s = 17'd6813;  7'd13: s = 17'd7371;  7'd14: s = 17'd7927;
            7'd15: s = 17'd8481;  7'd16: s = 17'd9032;  7'd17: s = 17'd9580;
            7'd18: s = 17'd10126; 7'd19: s = 17'd10668; 7'd20: s = 17'd11207;
            7'd21: s = 17'd11743; 7'd22: s = 17'd12275; 7'd23: s = 17'd12803;
            7'd24: s = 17'd13328; 7'd25: s = 17'd13848; 7'd26: s = 17'd14365;
            7'd27: s = 17'd14876; 7'd28: s = 17'd15384; 7'd29: s = 17'd15886;
            7'd30: s = 17'd16384; 7'd31: s = 17'd16877; 7'd32: s = 17'd17364;
            7'd33: s = 17'd17847; 7'd34: s = 17'd18324; 7'd35: s = 17'd18795;
            7'd36: s = 17'd19261; 7'd37: s = 17'd19720; 7'd38: s = 17'd20174;
            7'd39: s = 17'd20622; 7'd40: s = 17'd21063; 7'd41: s = 17'd21498;
            7'd42: s = 17'd21926; 7'd43: s = 17'd22348; 7'd44: s = 17'd22763;
            7'd45: s = 17'd23170; 7'd46: s = 17'd23571; 7'd47: s = 17'd23965;
            7'd48: s = 17'd24351; 7'd49: s = 17'd24730; 7'd50: s = 17'd25102;
            7'd51: s = 17'd25466; 7'd52: s = 17'd25822; 7'd53: s = 17'd26170;
            7'd54: s = 17'd26510; 7'd55: s = 17'd26842; 7'd56: s = 17'd27166;
            7'd57: s = 17'd27482; 7'd58: s = 17'd27789; 7'd59: s = 17'd28088;
            7'd60: s = 17'd28378; 7'd61: s = 17'd28660; 7'd62: s = 17'd28932;
            7'd63: s = 17'd29197; 7'd64: s = 17'd29452; 7'd65: s = 17'd29698;
            7'd66: s = 17'd29935; 7'd67: s = 17'd30163; 7'd68: s = 17'd30382;
            7'd69: s = 17'd30592; 7'd70: s = 17'd30792; 7'd71: s = 17'd30983;
            7'd72: s = 17'd31164; 7'd73: s = 17'd31336; 7'd74: s = 17'd31499;
            7'd75: s = 17'd31651; 7'd76: s = 17'd31795; 7'd77: s = 17'd31928;
            7'd78: s = 17'd32052; 7'd79: s = 17'd32166; 7'd80: s = 17'd32270;
            7'd81: s = 17'd32365; 7'd82: s = 17'd32449; 7'd83: s = 17'd32524;
            7'd84: s = 17'd32588; 7'd85: s = 17'd32643; 7'd86: s = 17'd32688;
            7'd87: s = 17'd32723; 7'd88: s = 17'd32748; 7'd89: s = 17'd32763;
            7'd90: s = 17'd32768;
            default: s = 17'd0;
        endcase
        return s;
    endfunction

endpackage

FILE: rtl/polar_unwrap_bilinear_sampler_unit.sv
// Polar unwrap bilinear sampler.
// Input channel (in_valid/in_stall): func 0 writes pixel_value at
// (pixel_row, pixel_col) into the frame store; func 1 asks for the grey value
// at angle_index*angle_step degrees and radius pixels from the center.
// Output channel (out_valid/out_stall) returns one sample per func 1 request.
// The store is split into four banks by row and column parity, so the four
// neighbours of any point are read together; one item enters per cycle
// unless in_stall is high. A sample passes angle wrap, trig lookup, radius
// multiply, position/clamp, bank read and two blend stages before out_valid.
// The pipeline is held whole while the output register is full and stalled;
// in_stall is high exactly then. Reset clears the valid bits and restores the
// registers (center 0,0, frame 640x480, step 1); pixel contents are not
// cleared and read as anything until written. A load enters the store at the
// bank-read stage, so a later sample always sees an earlier load. Write
// configuration via cfg_we/cfg_index/cfg_data only while idle; not enforced.
module polar_unwrap_bilinear_sampler_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [2:0]                  cfg_index,
    input  logic [10:0]                 cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        func,
    input  logic [pubs_pkg::COL_W-1:0]  pixel_col,
    input  logic [pubs_pkg::ROW_W-1:0]  pixel_row,
    input  logic [7:0]                  pixel_value,
    input  logic [8:0]                  angle_index,
    input  logic [9:0]                  radius,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [7:0]                  sample
);
    import pubs_pkg::*;

    localparam int HC = HALF_COL_W;
    localparam int HR = HALF_ROW_W;
    localparam int BD = 1 << (HC + HR);

    // configuration
    logic [COL_W-1:0] ccol_reg;
    logic [ROW_W-1:0] crow_reg;
    logic [10:0]      fw_reg;
    logic [9:0]       fh_reg;
    logic [8:0]       step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ccol_reg <= '0;
            crow_reg <= '0;
            fw_reg   <= 11'd640;
            fh_reg   <= 10'd480;
            step_reg <= 9'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CENTER_COL:   ccol_reg <= cfg_data[COL_W-1:0];
                REG_CENTER_ROW:   crow_reg <= cfg_data[ROW_W-1:0];
                REG_FRAME_WIDTH:  fw_reg <= cfg_data;
                REG_FRAME_HEIGHT: fh_reg <= cfg_data[9:0];
                REG_ANGLE_STEP:   step_reg <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // saturated frame size minus one
    logic [COL_W-1:0] wm1;
    logic [ROW_W-1:0] hm1;
    always_comb
    begin
        if (fw_reg == 11'd0)
            wm1 = '0;
        else if ({21'd0, fw_reg} > 32'(MAX_COLS))
            wm1 = COL_W'(MAX_COLS - 1);
        else
            wm1 = COL_W'(fw_reg - 11'd1);
        if (fh_reg == 10'd0)
            hm1 = '0;
        else if ({22'd0, fh_reg} > 32'(MAX_ROWS))
            hm1 = ROW_W'(MAX_ROWS - 1);
        else
            hm1 = ROW_W'(fh_reg - 10'd1);
    end

    // pipeline control: everything moves unless the output is full and stalled
    logic adv;
    logic out_valid_reg;
    assign adv = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    logic in_acc;
    assign in_acc = in_valid && adv;

    // stage 1: angle product
    logic        v1_reg, f1_reg;
    logic [17:0] prod1_reg;
    logic [9:0]  rad1_reg;
    logic [COL_W-1:0] pc1_reg;
    logic [ROW_W-1:0] pr1_reg;
    logic [7:0]  pv1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= in_acc;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_reg    <= func;
            prod1_reg <= 18'(angle_index) * 18'(step_reg);
            rad1_reg  <= radius;
            pc1_reg   <= pixel_col;
            pr1_reg   <= pixel_row;
            pv1_reg   <= pixel_value;
        end
    end

    // stage 2: modulo 360 by reciprocal, then quadrant split
    logic [36:0] q_mul;
    logic [9:0]  q_est;
    logic [18:0] r_est;
    logic [8:0]  deg;
    always_comb
    begin
        // 2^27/360 rounded up = 372828; exact for products below 2^18
        q_mul = 37'(prod1_reg) * 37'd372828;
        q_est = q_mul[36:27];
        r_est = 19'(prod1_reg) - 19'(q_est) * 19'd360;
        if (r_est >= 19'd360)
            deg = 9'(r_est - 19'd360);
        else
            deg = r_est[8:0];
    end

    logic [1:0] quad;
    logic [6:0] m;
    always_comb
    begin
        if (deg >= 9'd270)
        begin
            quad = 2'd3;
            m = 7'(deg - 9'd270);
        end
        else if (deg >= 9'd180)
        begin
            quad = 2'd2;
            m = 7'(deg - 9'd180);
        end
        else if (deg >= 9'd90)
        begin
            quad = 2'd1;
            m = 7'(deg - 9'd90);
        end
        else
        begin
            quad = 2'd0;
            m = deg[6:0];
        end
    end

    logic        v2_reg, f2_reg;
    logic [1:0]  quad2_reg;
    logic [6:0]  m2_reg;
    logic [9:0]  rad2_reg;
    logic [COL_W-1:0] pc2_reg;
    logic [ROW_W-1:0] pr2_reg;
    logic [7:0]  pv2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (adv)
            v2_reg <= v1_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f2_reg    <= f1_reg;
            quad2_reg <= quad;
            m2_reg    <= m;
            rad2_reg  <= rad1_reg;
            pc2_reg   <= pc1_reg;
            pr2_reg   <= pr1_reg;
            pv2_reg   <= pv1_reg;
        end
    end

    // stage 3: sine and cosine magnitudes with signs
    logic [16:0] sa, sb;
    assign sa = quarter_sine(m2_reg);
    assign sb = quarter_sine(7'd90 - m2_reg);

    logic [16:0] smag, cmag;
    logic        sneg, cneg;
    always_comb
    begin
        unique case (quad2_reg)
            2'd0: begin smag = sa; cmag = sb; sneg = 1'b0; cneg = 1'b0; end
            2'd1: begin smag = sb; cmag = sa; sneg = 1'b0; cneg = 1'b1; end
            2'd2: begin smag = sa; cmag = sb; sneg = 1'b1; cneg = 1'b1; end
            default: begin smag = sb; cmag = sa; sneg = 1'b1; cneg = 1'b0; end
        endcase
    end

    logic        v3_reg, f3_reg;
    logic [16:0] smag3_reg, cmag3_reg;
    logic        sneg3_reg, cneg3_reg;
    logic [9:0]  rad3_reg;
    logic [COL_W-1:0] pc3_reg;
    logic [ROW_W-1:0] pr3_reg;
    logic [7:0]  pv3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (adv)
            v3_reg <= v2_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f3_reg    <= f2_reg;
            smag3_reg <= smag;
            cmag3_reg <= cmag;
            sneg3_reg <= sneg;
            cneg3_reg <= cneg;
            rad3_reg  <= rad2_reg;
            pc3_reg   <= pc2_reg;
            pr3_reg   <= pr2_reg;
            pv3_reg   <= pv2_reg;
        end
    end

    // stage 4: offsets r*cos and -r*sin in Q16 (Q15 product shifted left)
    localparam int PW = 30;
    logic [26:0] xo_mag, yo_mag;
    assign xo_mag = 27'(rad3_reg) * 27'(cmag3_reg);
    assign yo_mag = 27'(rad3_reg) * 27'(smag3_reg);

    logic        v4_reg, f4_reg;
    logic signed [PW-1:0] xoff4_reg, yoff4_reg;
    logic [COL_W-1:0] pc4_reg;
    logic [ROW_W-1:0] pr4_reg;
    logic [7:0]  pv4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (adv)
            v4_reg <= v3_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f4_reg    <= f3_reg;
            xoff4_reg <= cneg3_reg ? -$signed({2'b0, xo_mag, 1'b0})
                                   : $signed({2'b0, xo_mag, 1'b0});
            yoff4_reg <= sneg3_reg ? $signed({2'b0, yo_mag, 1'b0})
                                   : -$signed({2'b0, yo_mag, 1'b0});
            pc4_reg   <= pc3_reg;
            pr4_reg   <= pr3_reg;
            pv4_reg   <= pv3_reg;
        end
    end

    // stage 5: positions, case decision, pick coordinates
    localparam int XW = PW + 2;
    logic signed [XW-1:0] xp, yp;
    assign xp = $signed({{(XW-COL_W-16){1'b0}}, ccol_reg, 16'd0}) + XW'(xoff4_reg);
    assign yp = $signed({{(XW-ROW_W-16){1'b0}}, crow_reg, 16'd0}) + XW'(yoff4_reg);

    logic signed [XW-17:0] x0, y0;
    logic [15:0] fx, fy;
    assign x0 = xp[XW-1:16];
    assign y0 = yp[XW-1:16];
    assign fx = xp[15:0];
    assign fy = yp[15:0];

    logic signed [XW-17:0] wm1s, hm1s;
    assign wm1s = (XW-16)'(wm1);
    assign hm1s = (XW-16)'(hm1);

    logic blend;
    logic [COL_W-1:0] pxc;
    logic [ROW_W-1:0] pyc;
    logic xpos, ypos, xbig, ybig;
    always_comb
    begin
        xpos = xp > 0;
        ypos = yp > 0;
        // X < (W-1)*65536  <=>  x0 < W-1 (fraction nonzero here)
        blend = (fx != 16'd0) && (fy != 16'd0) && xpos && ypos &&
                (x0 < wm1s) && (y0 < hm1s);
        // X > W*65536 with nonzero fraction <=> x0 >= W
        xbig = x0 >= (wm1s + (XW-16)'(1));
        ybig = y0 >= (hm1s + (XW-16)'(1));
        if (fx == 16'd0 || fy == 16'd0 || blend)
        begin
            pxc = (x0 < 0) ? '0 : ((x0 > wm1s) ? wm1 : x0[COL_W-1:0]);
            pyc = (y0 < 0) ? '0 : ((y0 > hm1s) ? hm1 : y0[ROW_W-1:0]);
        end
        else
        begin
            pxc = !xpos ? '0 : ((xbig || x0 > wm1s) ? wm1 : x0[COL_W-1:0]);
            pyc = !ypos ? '0 : ((ybig || y0 > hm1s) ? hm1 : y0[ROW_W-1:0]);
        end
    end

    logic        v5_reg, f5_reg, bl5_reg;
    logic [COL_W-1:0] c5_reg;
    logic [ROW_W-1:0] r5_reg;
    logic [15:0] fx5_reg, fy5_reg;
    logic [7:0]  pv5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (adv)
            v5_reg <= v4_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f5_reg  <= f4_reg;
            bl5_reg <= blend;
            c5_reg  <= (f4_reg == FUNC_LOAD) ? pc4_reg : pxc;
            r5_reg  <= (f4_reg == FUNC_LOAD) ? pr4_reg : pyc;
            fx5_reg <= fx;
            fy5_reg <= fy;
            pv5_reg <= pv4_reg;
        end
    end

    // frame store: four parity banks; write and read at stage 5
    logic [7:0] bank0 [BD];
    logic [7:0] bank1 [BD];
    logic [7:0] bank2 [BD];
    logic [7:0] bank3 [BD];

    // neighbour addresses: c and c+1, r and r+1
    logic [COL_W-1:0] c1;
    logic [ROW_W-1:0] r1;
    assign c1 = c5_reg + COL_W'(1);
    assign r1 = r5_reg + ROW_W'(1);

    logic [HC-1:0] ce, co;
    logic [HR-1:0] re, ro;
    always_comb
    begin
        // even column of the pair, odd column of the pair
        ce = c5_reg[0] ? c1[COL_W-1:1] : c5_reg[COL_W-1:1];
        co = c5_reg[COL_W-1:1];
        re = r5_reg[0] ? r1[ROW_W-1:1] : r5_reg[ROW_W-1:1];
        ro = r5_reg[ROW_W-1:1];
    end

    logic load5;
    assign load5 = v5_reg && adv && (f5_reg == FUNC_LOAD);
    logic [1:0] wbank;
    assign wbank = {r5_reg[0], c5_reg[0]};
    logic [HC+HR-1:0] waddr;
    assign waddr = {r5_reg[ROW_W-1:1], c5_reg[COL_W-1:1]};

    logic [7:0] q_ee, q_eo, q_oe, q_oo;
    always_ff @(posedge clk)
    begin
        if (load5 && wbank == 2'd0) bank0[waddr] <= pv5_reg;
        if (load5 && wbank == 2'd1) bank1[waddr] <= pv5_reg;
        if (load5 && wbank == 2'd2) bank2[waddr] <= pv5_reg;
        if (load5 && wbank == 2'd3) bank3[waddr] <= pv5_reg;
        if (adv)
        begin
            q_ee <= bank0[{re, ce}];
            q_eo <= bank1[{re, co}];
            q_oe <= bank2[{ro, ce}];
            q_oo <= bank3[{ro, co}];
        end
    end

    // stage 6: route banks to p00..p11 and form weighted products
    logic        v6_reg, bl6_reg, cp6_reg, rp6_reg;
    logic [15:0] fx6_reg, fy6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v6_reg <= 1'b0;
        else if (adv)
            v6_reg <= v5_reg && (f5_reg == FUNC_SAMPLE);
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bl6_reg <= bl5_reg;
            cp6_reg <= c5_reg[0];
            rp6_reg <= r5_reg[0];
            fx6_reg <= fx5_reg;
            fy6_reg <= fy5_reg;
        end
    end

    logic [7:0] p00, p01, p10, p11;
    always_comb
    begin
        logic [7:0] t0l, t0h, t1l, t1h;
        t0l = cp6_reg ? q_eo : q_ee;
        t0h = cp6_reg ? q_ee : q_eo;
        t1l = cp6_reg ? q_oo : q_oe;
        t1h = cp6_reg ? q_oe : q_oo;
        p00 = rp6_reg ? t1l : t0l;
        p01 = rp6_reg ? t1h : t0h;
        p10 = rp6_reg ? t0l : t1l;
        p11 = rp6_reg ? t0h : t1h;
    end

    logic [16:0] bx, by;
    assign bx = 17'h10000 - 17'(fx6_reg);
    assign by = 17'h10000 - 17'(fy6_reg);

    // row blends in Q16: top and bottom
    logic [24:0] top, bot;
    assign top = 25'(bx) * 25'(p00) + 25'(fx6_reg) * 25'(p01);
    assign bot = 25'(bx) * 25'(p10) + 25'(fx6_reg) * 25'(p11);

    logic        v7_reg, bl7_reg;
    logic [24:0] top7_reg, bot7_reg;
    logic [16:0] by7_reg;
    logic [15:0] fy7_reg;
    logic [7:0]  p007_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v7_reg <= 1'b0;
        else if (adv)
            v7_reg <= v6_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bl7_reg  <= bl6_reg;
            top7_reg <= top;
            bot7_reg <= bot;
            by7_reg  <= by;
            fy7_reg  <= fy6_reg;
            p007_reg <= p00;
        end
    end

    // stage 7: column blend, truncate; non-blend cases pass p00
    logic [41:0] acc;
    assign acc = 42'(top7_reg) * 42'(by7_reg) + 42'(bot7_reg) * 42'(fy7_reg);

    logic [7:0] sample_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= v7_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
            sample_reg <= bl7_reg ? acc[39:32] : p007_reg;
    end

    assign out_valid = out_valid_reg;
    assign sample = sample_reg;

endmodule

FILE: rtl/pubs_checker.sv
module pubs_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic [7:0] sample
);
    // output word holds while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample))
        else $error("sample changed under stall");

    // input stalls only when the output is full and stalled
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without back pressure");

    // free output side keeps the input open
    a_open: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output free");

    // handshake lines are known out of reset
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({in_valid, in_stall, out_valid}))
        else $error("handshake line unknown");

endmodule

bind polar_unwrap_bilinear_sampler_unit pubs_checker u_pubs_checker
(
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sample(sample)
);
